FILE: hw/rtl/mhef_pkg.sv
// Shared types, constants and codes of the mouse hotkey event filter.
`default_nettype none

package mhef_pkg;

   localparam int unsigned WHEEL_UNIT          = 120;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
   localparam int unsigned CSR_ADDR_W          = 3;
   localparam int unsigned CSR_DATA_W          = 32;

   localparam logic [15:0] IDLE_MS_RESET   = 16'd500;
   localparam logic [15:0] REPEAT_MS_RESET = 16'd250;
   localparam logic [2:0]  MODS_MAX        = 3'd7;

   // floor(x / 120) == (x * RECIP_MULT) >> RECIP_SHIFT for every 16-bit x
   localparam logic [15:0] RECIP_MULT  = 16'd34953;
   localparam int unsigned RECIP_SHIFT = 22;
   localparam int unsigned QUOT_W      = $clog2((1 << 16) / WHEEL_UNIT + 1);

   localparam logic [15:0] MSG_LBUTTONDOWN   = 16'h0201;
   localparam logic [15:0] MSG_LBUTTONUP     = 16'h0202;
   localparam logic [15:0] MSG_LBUTTONDBLCLK = 16'h0203;
   localparam logic [15:0] MSG_RBUTTONDOWN   = 16'h0204;
   localparam logic [15:0] MSG_RBUTTONUP     = 16'h0205;
   localparam logic [15:0] MSG_RBUTTONDBLCLK = 16'h0206;
   localparam logic [15:0] MSG_MBUTTONDOWN   = 16'h0207;
   localparam logic [15:0] MSG_MBUTTONUP     = 16'h0208;
   localparam logic [15:0] MSG_MBUTTONDBLCLK = 16'h0209;
   localparam logic [15:0] MSG_MOUSEWHEEL    = 16'h020A;
   localparam logic [15:0] MSG_XBUTTONDOWN   = 16'h020B;
   localparam logic [15:0] MSG_XBUTTONUP     = 16'h020C;
   localparam logic [15:0] MSG_XBUTTONDBLCLK = 16'h020D;
   localparam logic [15:0] MSG_MOUSEHWHEEL   = 16'h020E;

   localparam logic [15:0] XBUTTON_1 = 16'd1;
   localparam logic [15:0] XBUTTON_2 = 16'd2;

   localparam logic [3:0] BTN_LEFT        = 4'd0;
   localparam logic [3:0] BTN_RIGHT       = 4'd1;
   localparam logic [3:0] BTN_MIDDLE      = 4'd2;
   localparam logic [3:0] BTN_X1          = 4'd3;
   localparam logic [3:0] BTN_X2          = 4'd4;
   localparam logic [3:0] BTN_WHEEL_UP    = 4'd5;
   localparam logic [3:0] BTN_WHEEL_DOWN  = 4'd6;
   localparam logic [3:0] BTN_WHEEL_LEFT  = 4'd7;
   localparam logic [3:0] BTN_WHEEL_RIGHT = 4'd8;

   typedef enum logic {
      CSR_WHEEL_IDLE   = 1'b0,
      CSR_WHEEL_REPEAT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [15:0] message;
      logic [15:0] data_high;
      logic        injected;
      logic [3:0]  modifiers;
      logic [31:0] now_ms;
   } req_data_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] button;
      logic [2:0] mods_out;
   } rsp_data_type;

   typedef struct packed {
      logic        known;
      logic        is_wheel;
      logic [3:0]  button;
      logic        is_down;
      logic [3:0]  mods;
      logic        mag_big;
      logic [6:0]  mag_res;
      logic [31:0] now_ms;
   } event_type;

   typedef struct packed {
      logic [15:0] idle_ms;
      logic [15:0] repeat_ms;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mhef_fifo.sv
// Small register queue with count, used between the front and back ends and at the output.
`default_nettype none

module mhef_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mhef_front.sv
// Front end: accepts mouse events, decodes them and reduces the wheel magnitude modulo 120.
`default_nettype none

module mhef_front
   import mhef_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire req_data_type req_data,
   output logic              evt_push,
   output event_type         evt_data,
   input  wire logic         evt_full
);

   event_type         dec;
   logic [15:0]       mag;
   logic              recognized;
   logic              neg;
   logic [31:0]       prod;
   logic              load;

   logic              s1_valid_ff, s1_valid_in;
   event_type         s1_evt_ff;
   logic [15:0]       s1_mag_ff;
   logic [QUOT_W-1:0] s1_quot_ff;
   logic [15:0]       quot_times_unit;
   logic [15:0]       rem;

   always_comb begin
      recognized   = 1'b1;
      neg          = req_data.data_high[15];
      mag          = '0;
      dec          = '0;
      dec.mods     = req_data.modifiers;
      dec.now_ms   = req_data.now_ms;
      dec.is_down  = 1'b1;
      unique case (req_data.message) inside
         MSG_LBUTTONDOWN, MSG_LBUTTONDBLCLK: begin
            dec.button = BTN_LEFT;
         end
         MSG_LBUTTONUP: begin
            dec.button  = BTN_LEFT;
            dec.is_down = 1'b0;
         end
         MSG_RBUTTONDOWN, MSG_RBUTTONDBLCLK: begin
            dec.button = BTN_RIGHT;
         end
         MSG_RBUTTONUP: begin
            dec.button  = BTN_RIGHT;
            dec.is_down = 1'b0;
         end
         MSG_MBUTTONDOWN, MSG_MBUTTONDBLCLK: begin
            dec.button = BTN_MIDDLE;
         end
         MSG_MBUTTONUP: begin
            dec.button  = BTN_MIDDLE;
            dec.is_down = 1'b0;
         end
         MSG_XBUTTONDOWN, MSG_XBUTTONUP, MSG_XBUTTONDBLCLK: begin
            recognized  = (req_data.data_high == XBUTTON_1) ||
                          (req_data.data_high == XBUTTON_2);
            dec.button  = (req_data.data_high == XBUTTON_1) ? BTN_X1 : BTN_X2;
            dec.is_down = (req_data.message != MSG_XBUTTONUP);
         end
         MSG_MOUSEWHEEL: begin
            recognized   = (req_data.data_high != '0);
            dec.is_wheel = 1'b1;
            dec.button   = neg ? BTN_WHEEL_DOWN : BTN_WHEEL_UP;
            mag          = neg ? (~req_data.data_high + 16'd1) : req_data.data_high;
         end
         MSG_MOUSEHWHEEL: begin
            recognized   = (req_data.data_high != '0);
            dec.is_wheel = 1'b1;
            dec.button   = neg ? BTN_WHEEL_LEFT : BTN_WHEEL_RIGHT;
            mag          = neg ? (~req_data.data_high + 16'd1) : req_data.data_high;
         end
         default: begin
            recognized = 1'b0;
         end
      endcase
      dec.known = recognized && !req_data.injected;
   end

   assign prod = 32'(mag) * 32'(RECIP_MULT);

   assign full        = s1_valid_ff && evt_full;
   assign load        = !full;
   assign s1_valid_in = load ? push : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && push) begin
         s1_evt_ff  <= dec;
         s1_mag_ff  <= mag;
         s1_quot_ff <= QUOT_W'(prod >> RECIP_SHIFT);
      end
   end

   assign quot_times_unit = 16'(s1_quot_ff) * 16'(WHEEL_UNIT);
   assign rem             = s1_mag_ff - quot_times_unit;

   always_comb begin
      evt_data         = s1_evt_ff;
      evt_data.mag_big = (s1_mag_ff >= 16'(WHEEL_UNIT));
      evt_data.mag_res = rem[6:0];
   end

   assign evt_push = s1_valid_ff && !evt_full;

endmodule

`default_nettype wire

FILE: hw/rtl/mhef_back.sv
// Back end: applies decoded events to the button and wheel state and builds one result each.
`default_nettype none

module mhef_back
   import mhef_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      evt_empty,
   output logic           evt_pop,
   input  wire event_type evt_data,
   input  wire logic      rsp_full,
   output logic           rsp_push,
   output rsp_data_type   rsp_data
);

   logic [4:0]  held_ff, held_in;
   logic [7:0]  wheel_key_ff, wheel_key_in;
   logic [31:0] last_wheel_ff, last_wheel_in;
   logic [6:0]  accum_ff, accum_in;
   logic        trig_ff, trig_in;
   logic [31:0] last_trig_time_ff, last_trig_time_in;
   logic [7:0]  last_trig_key_ff, last_trig_key_in;

   logic [7:0]  key;
   logic [31:0] dt_wheel, dt_trig;
   logic        idle;
   logic [6:0]  acc_base;
   logic [7:0]  acc_sum;
   logic        wrap;
   logic        blocked;
   logic        repeated;
   logic        fire;
   logic        step;

   assign evt_pop  = !evt_empty && !rsp_full;
   assign rsp_push = evt_pop;
   assign step     = evt_pop && evt_data.known;

   assign key      = {evt_data.mods, evt_data.button};
   assign dt_wheel = evt_data.now_ms - last_wheel_ff;
   assign dt_trig  = evt_data.now_ms - last_trig_time_ff;
   assign idle     = dt_wheel > {16'd0, cfg.idle_ms};
   assign acc_base = ((key != wheel_key_ff) || idle) ? '0 : accum_ff;
   assign acc_sum  = {1'b0, acc_base} + {1'b0, evt_data.mag_res};
   assign wrap     = acc_sum >= 8'(WHEEL_UNIT);
   assign blocked  = trig_ff && (key == last_trig_key_ff) &&
                     (dt_trig < {16'd0, cfg.repeat_ms});
   assign repeated = held_ff[evt_data.button[2:0]];

   always_comb begin
      held_in           = held_ff;
      wheel_key_in      = wheel_key_ff;
      last_wheel_in     = last_wheel_ff;
      accum_in          = accum_ff;
      trig_in           = trig_ff;
      last_trig_time_in = last_trig_time_ff;
      last_trig_key_in  = last_trig_key_ff;
      fire              = 1'b0;
      if (step) begin
         if (evt_data.is_wheel) begin
            wheel_key_in  = key;
            last_wheel_in = evt_data.now_ms;
            accum_in      = wrap ? 7'(acc_sum - 8'(WHEEL_UNIT)) : acc_sum[6:0];
            if ((evt_data.mag_big || wrap) && !blocked) begin
               trig_in           = 1'b1;
               last_trig_time_in = evt_data.now_ms;
               last_trig_key_in  = key;
               fire              = 1'b1;
            end
         end else begin
            held_in[evt_data.button[2:0]] = evt_data.is_down;
            fire                          = evt_data.is_down && !repeated;
         end
      end
   end

   always_comb begin
      rsp_data = '0;
      if (fire && (evt_data.mods <= {1'b0, MODS_MAX})) begin
         rsp_data.hit      = 1'b1;
         rsp_data.button   = evt_data.button;
         rsp_data.mods_out = evt_data.mods[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff           <= '0;
         wheel_key_ff      <= '0;
         last_wheel_ff     <= '0;
         accum_ff          <= '0;
         trig_ff           <= 1'b0;
         last_trig_time_ff <= '0;
         last_trig_key_ff  <= '0;
      end else begin
         held_ff           <= held_in;
         wheel_key_ff      <= wheel_key_in;
         last_wheel_ff     <= last_wheel_in;
         accum_ff          <= accum_in;
         trig_ff           <= trig_in;
         last_trig_time_ff <= last_trig_time_in;
         last_trig_key_ff  <= last_trig_key_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mouse_hotkey_event_filter_core.sv
// Mouse hotkey event filter: top level with register port, front end, event queue, back end.
// Takes one mouse event beat per clock while full is low and returns exactly one result beat
// per event, in order. Sustained rate is one beat per clock while results are popped; each
// result passes the decode stage register, the event queue, the back end state update and the
// result queue. The back end state update sets the rate. Injected, unknown and malformed
// events still return a result with hit low. Registers: wheel_idle_ms at byte 0,
// wheel_repeat_ms at byte 4, 16 bits each; write them only while no event is in flight.
`default_nettype none

module mouse_hotkey_event_filter_core
   import mhef_pkg::*;
#(
   parameter int unsigned EVT_QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int unsigned RSP_QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire req_data_type          req_data,
   output logic                       empty,
   input  wire logic                  pop,
   output rsp_data_type               rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   cfg_type      cfg_ff, cfg_in;
   csr_reg_type  csr_sel;
   logic         csr_wr;

   logic         fe_push;
   event_type    fe_data;
   logic         evq_full;
   logic         evq_empty;
   logic         evq_pop;
   event_type    evq_data;
   logic         be_push;
   rsp_data_type be_data;
   logic         rspq_full;

   assign pready  = 1'b1;
   assign csr_sel = csr_reg_type'(paddr[2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (csr_sel)
         CSR_WHEEL_IDLE: begin
            prdata = CSR_DATA_W'(cfg_ff.idle_ms);
            if (csr_wr) begin
               cfg_in.idle_ms = pwdata[15:0];
            end
         end
         CSR_WHEEL_REPEAT: begin
            prdata = CSR_DATA_W'(cfg_ff.repeat_ms);
            if (csr_wr) begin
               cfg_in.repeat_ms = pwdata[15:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_ms   <= IDLE_MS_RESET;
         cfg_ff.repeat_ms <= REPEAT_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mhef_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .evt_push (fe_push),
      .evt_data (fe_data),
      .evt_full (evq_full)
   );

   mhef_fifo #(
      .WIDTH ($bits(event_type)),
      .DEPTH (EVT_QUEUE_DEPTH)
   ) u_evt_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fe_push),
      .wr_data (fe_data),
      .full    (evq_full),
      .rd_en   (evq_pop),
      .rd_data (evq_data),
      .empty   (evq_empty)
   );

   mhef_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .evt_empty (evq_empty),
      .evt_pop   (evq_pop),
      .evt_data  (evq_data),
      .rsp_full  (rspq_full),
      .rsp_push  (be_push),
      .rsp_data  (be_data)
   );

   mhef_fifo #(
      .WIDTH ($bits(rsp_data_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (be_push),
      .wr_data (be_data),
      .full    (rspq_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/mhef_checker.sv
// Port-level checker of the mouse hotkey event filter and its bind to the top level.
`default_nettype none

module mhef_checker
   import mhef_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  full,
   input wire logic                  empty,
   input wire logic                  pop,
   input wire rsp_data_type          rsp_data,
   input wire logic                  psel,
   input wire logic                  penable,
   input wire logic                  pwrite,
   input wire logic [CSR_ADDR_W-1:0] paddr,
   input wire logic [CSR_DATA_W-1:0] pwdata,
   input wire logic [CSR_DATA_W-1:0] prdata,
   input wire logic                  pready
);

   a_reset_clears: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not cleared by reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.hit) |-> (rsp_data.button == '0 && rsp_data.mods_out == '0))
      else $error("result without hit carries nonzero fields");

   a_button_range: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.hit) |-> (rsp_data.button <= BTN_WHEEL_RIGHT))
      else $error("hit reports an undefined button");

   a_idle_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result beat changed or vanished");

   a_cfg_write_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && !$past(reset)) ##1
      ($stable(paddr) && !(psel && penable && pwrite)) |->
      (prdata[15:0] == $past(pwdata[15:0])))
      else $error("register readback differs from written value");

endmodule

bind mouse_hotkey_event_filter_core mhef_checker u_mhef_checker (.*);

`default_nettype wire
